FILE: rtl/core/mkd_pkg.sv
package mkd_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int GLYPH_COUNT    = 37;
	localparam int GLYPH_W        = 6;
	localparam int SLOT_OUT_W     = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;

	localparam logic [GLYPH_W-1:0] UNKNOWN_GLYPH = 6'd26;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECODE_GAP_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TICKS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DASH_LIMIT       = 2'd3;

	localparam logic [15:0] DEBOUNCE_LIMIT_RST   = 16'd20;
	localparam logic [15:0] DECODE_GAP_LIMIT_RST = 16'd300;
	localparam logic [7:0]  COLUMN_TICKS_RST     = 8'd10;
	localparam logic [7:0]  DASH_LIMIT_RST       = 8'd3;

	// Symbol patterns with a trailing one appended; the unknown entry is never matched.
	localparam logic [7:0] MORSE_PATTERNS [GLYPH_COUNT] = '{
		8'h0B, 8'h31, 8'h35, 8'h19, 8'h05, 8'h25, 8'h1D, 8'h21, 8'h09, 8'h2F,
		8'h1B, 8'h29, 8'h0F, 8'h0D, 8'h1F, 8'h2D, 8'h3B, 8'h15, 8'h11, 8'h07,
		8'h13, 8'h23, 8'h17, 8'h33, 8'h37, 8'h39, 8'h00, 8'h5F, 8'h4F, 8'h47,
		8'h43, 8'h41, 8'h61, 8'h71, 8'h79, 8'h7D, 8'h7F
	};

	typedef enum logic [1:0] {
		EV_NONE,
		EV_DOWN,
		EV_UP,
		EV_GAP
	} key_ev_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_MARK,
		ACT_SPACE,
		ACT_GAP
	} line_act_t;

	typedef struct packed {
		logic                  tone_on;
		line_act_t             line_action;
		logic                  char_valid;
		logic [GLYPH_W-1:0]    char_index;
		logic [SLOT_OUT_W-1:0] char_slot;
		logic                  row_wrapped;
	} line_res_t;

	function automatic logic [GLYPH_W-1:0] glyph_lookup(input logic [7:0] sym);
		logic [7:0]         pat;
		logic [GLYPH_W-1:0] glyph;
		pat   = {sym[6:0], 1'b1};
		glyph = UNKNOWN_GLYPH;
		for (int i = 0; i < GLYPH_COUNT; i++) begin
			if (i != int'(UNKNOWN_GLYPH) && MORSE_PATTERNS[i] == pat) begin
				glyph = GLYPH_W'(i);
			end
		end
		return glyph;
	endfunction

endpackage

FILE: rtl/core/mkd_key_if.sv
interface mkd_key_if;
	logic valid;
	logic ready;
	logic key_pressed;

	modport source (output valid, output key_pressed, input ready);
	modport sink (input valid, input key_pressed, output ready);
endinterface

FILE: rtl/core/mkd_res_if.sv
interface mkd_res_if import mkd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  tone_on;
	logic [1:0]            line_action;
	logic                  char_valid;
	logic [GLYPH_W-1:0]    char_index;
	logic [SLOT_OUT_W-1:0] char_slot;
	logic                  row_wrapped;

	modport source (output valid, output tone_on, output line_action, output char_valid,
		output char_index, output char_slot, output row_wrapped, input ready);
	modport sink (input valid, input tone_on, input line_action, input char_valid,
		input char_index, input char_slot, input row_wrapped, output ready);
endinterface

FILE: rtl/core/mkd_cfg_if.sv
interface mkd_cfg_if import mkd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/mkd_key_fsm.sv
module mkd_key_fsm import mkd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        pressed,
	input  logic [15:0] debounce_limit,
	input  logic [15:0] decode_gap_limit,
	output key_ev_t     ev
);

	typedef enum logic [1:0] {
		KEY_IDLE,
		KEY_DOWN,
		KEY_UP
	} key_mode_t;

	key_mode_t   mode_q, mode_d;
	logic [15:0] release_q, release_d;
	logic [15:0] gap_q, gap_d;
	logic [15:0] release_inc;
	logic [15:0] gap_inc;

	assign release_inc = (release_q == 16'hFFFF) ? release_q : release_q + 16'd1;
	assign gap_inc     = (gap_q == 16'hFFFF) ? gap_q : gap_q + 16'd1;

	always_comb begin
		mode_d    = mode_q;
		release_d = release_q;
		gap_d     = gap_q;
		ev        = EV_NONE;
		unique case (mode_q)
			KEY_DOWN: begin
				if (pressed) begin
					release_d = '0;
				end else if (release_inc > debounce_limit) begin
					ev        = EV_UP;
					release_d = '0;
					mode_d    = KEY_UP;
				end else begin
					release_d = release_inc;
				end
			end
			KEY_UP: begin
				if (pressed) begin
					gap_d  = '0;
					ev     = EV_DOWN;
					mode_d = KEY_DOWN;
				end else if (gap_inc > decode_gap_limit) begin
					ev     = EV_GAP;
					gap_d  = '0;
					mode_d = KEY_IDLE;
				end else begin
					gap_d = gap_inc;
				end
			end
			default: begin
				mode_d = KEY_IDLE;
				if (pressed) begin
					ev     = EV_DOWN;
					mode_d = KEY_DOWN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= KEY_IDLE;
			release_q <= '0;
			gap_q     <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			release_q <= release_d;
			gap_q     <= gap_d;
		end
	end

endmodule

FILE: rtl/core/mkd_line_fsm.sv
module mkd_line_fsm import mkd_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  key_ev_t    ev,
	input  logic [7:0] column_ticks,
	input  logic [7:0] dash_limit,
	output line_res_t  res
);

	localparam int SLOT_CNT_W = ($clog2(SLOT_COUNT + 1) > SLOT_OUT_W) ?
		$clog2(SLOT_COUNT + 1) : SLOT_OUT_W;

	typedef enum logic [1:0] {
		LINE_IDLE,
		LINE_DOWN,
		LINE_UP,
		LINE_GAP
	} line_mode_t;

	line_mode_t            mode_q, mode_d, mode_cur;
	logic [7:0]            column_q, column_d, column_cur, column_inc;
	logic [7:0]            mark_q, mark_d;
	logic [7:0]            symbol_q, symbol_d;
	logic [SLOT_CNT_W-1:0] slot_q, slot_d, slot_use;
	logic                  wrap;

	assign mode_cur   = (ev != EV_NONE) ? line_mode_t'(ev) : mode_q;
	assign column_cur = (ev != EV_NONE) ? 8'd0 : column_q;
	assign column_inc = (column_cur == 8'hFF) ? column_cur : column_cur + 8'd1;
	assign wrap       = (slot_q >= SLOT_CNT_W'(SLOT_COUNT));
	assign slot_use   = wrap ? '0 : slot_q;

	always_comb begin
		mode_d   = mode_cur;
		column_d = column_cur;
		mark_d   = mark_q;
		symbol_d = symbol_q;
		slot_d   = slot_q;
		res      = '0;
		unique case (mode_cur)
			LINE_DOWN: begin
				res.tone_on = 1'b1;
				column_d    = column_inc;
				if (column_inc > column_ticks) begin
					res.line_action = ACT_MARK;
					mark_d          = (mark_q == 8'hFF) ? mark_q : mark_q + 8'd1;
					column_d        = '0;
				end
			end
			LINE_UP: begin
				column_d = column_inc;
				if (column_inc > column_ticks) begin
					res.line_action = ACT_SPACE;
					if (mark_q != 8'd0) begin
						symbol_d = {symbol_q[6:0], (mark_q > dash_limit)};
						mark_d   = '0;
					end
					column_d = '0;
				end
			end
			LINE_GAP: begin
				res.line_action = ACT_GAP;
				res.char_valid  = 1'b1;
				res.char_index  = glyph_lookup(symbol_q);
				res.char_slot   = slot_use[SLOT_OUT_W-1:0];
				res.row_wrapped = wrap;
				slot_d          = slot_use + SLOT_CNT_W'(1);
				symbol_d        = 8'd1;
				mode_d          = LINE_IDLE;
			end
			default: begin
				mode_d = LINE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= LINE_IDLE;
			column_q <= '0;
			mark_q   <= '0;
			symbol_q <= 8'd1;
			slot_q   <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			column_q <= column_d;
			mark_q   <= mark_d;
			symbol_q <= symbol_d;
			slot_q   <= slot_d;
		end
	end

endmodule

FILE: rtl/core/morse_key_decoder.sv
// Morse key decoder. Each request on the key channel is one tick carrying the key level,
// and each produces exactly one result request holding the sidetone enable, the scroll
// column action and, on a character gap, the decoded glyph with its display slot. A tick
// is registered at the input, passes the key and line state machines combinationally and
// lands in the result register, so one tick is taken every clock cycle unless the result
// channel stalls; the result register lets the next tick enter while a result waits to be
// taken. The four timing registers are written through the configuration channel, which
// is always ready, and should be changed only while no ticks are in flight.
module morse_key_decoder import mkd_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mkd_cfg_if.sink    cfg,
	mkd_key_if.sink    key,
	mkd_res_if.source  result
);

	logic [15:0] debounce_limit_q;
	logic [15:0] decode_gap_limit_q;
	logic [7:0]  column_ticks_q;
	logic [7:0]  dash_limit_q;

	logic        valid_s1;
	logic        key_s1;
	logic        out_valid_q;
	line_res_t   out_q;
	logic        step;
	logic        out_free;
	key_ev_t     ev;
	line_res_t   line_res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q   <= DEBOUNCE_LIMIT_RST;
			decode_gap_limit_q <= DECODE_GAP_LIMIT_RST;
			column_ticks_q     <= COLUMN_TICKS_RST;
			dash_limit_q       <= DASH_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_DEBOUNCE_LIMIT:   debounce_limit_q   <= cfg.data;
				CFG_DECODE_GAP_LIMIT: decode_gap_limit_q <= cfg.data;
				CFG_COLUMN_TICKS:     column_ticks_q     <= cfg.data[7:0];
				CFG_DASH_LIMIT:       dash_limit_q       <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	assign out_free  = !out_valid_q || result.ready;
	assign step      = valid_s1 && out_free;
	assign key.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key.ready) begin
			valid_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key.ready && key.valid) begin
			key_s1 <= key.key_pressed;
		end
	end

	mkd_key_fsm u_key_fsm (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.pressed          (key_s1),
		.debounce_limit   (debounce_limit_q),
		.decode_gap_limit (decode_gap_limit_q),
		.ev               (ev)
	);

	mkd_line_fsm #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_line_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.ev           (ev),
		.column_ticks (column_ticks_q),
		.dash_limit   (dash_limit_q),
		.res          (line_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= line_res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.tone_on     = out_q.tone_on;
	assign result.line_action = 2'(out_q.line_action);
	assign result.char_valid  = out_q.char_valid;
	assign result.char_index  = out_q.char_index;
	assign result.char_slot   = out_q.char_slot;
	assign result.row_wrapped = out_q.row_wrapped;

	a_char_on_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.char_valid == (out_q.line_action == ACT_GAP)))
		else $error("character flag and gap action disagree");

	a_char_fields_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.char_valid) |->
		(out_q.char_index == '0 && out_q.char_slot == '0 && !out_q.row_wrapped))
		else $error("character fields set without a character");

	a_wrap_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.row_wrapped) |-> (out_q.char_slot == '0))
		else $error("wrapped character not in slot zero");

	a_tone_action: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.tone_on) |->
		(out_q.line_action == ACT_NONE || out_q.line_action == ACT_MARK))
		else $error("sidetone on outside a mark");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> key.ready)
		else $error("input stalled with an empty result register");

endmodule

FILE: dv/morse_key_decoder_test.sv
`timescale 1ns / 1ps

module morse_key_decoder_test;
	import mkd_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PRINT_LIMIT = 20;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_DOWN,
		MODE_UP,
		MODE_GAP
	} mode_t;

	class decode_tracker;
		bit [15:0] debounce_lim;
		bit [15:0] gap_lim;
		bit [7:0] col_ticks;
		bit [7:0] dash_lim;
		mode_t key_mode;
		mode_t line_mode;
		bit [15:0] release_cnt;
		bit [15:0] gap_cnt;
		bit [7:0] column_cnt;
		bit [7:0] mark_cols;
		bit [7:0] symbol;
		bit [4:0] slot_pos;
		bit [7:0] glyph_codes [GLYPH_COUNT];
		line_res_t pending_results [$];
		int errors;
		int chars_seen;
		int ticks_seen;

		function new();
			glyph_codes = '{
				8'h0B, 8'h31, 8'h35, 8'h19, 8'h05, 8'h25, 8'h1D, 8'h21, 8'h09, 8'h2F,
				8'h1B, 8'h29, 8'h0F, 8'h0D, 8'h1F, 8'h2D, 8'h3B, 8'h15, 8'h11, 8'h07,
				8'h13, 8'h23, 8'h17, 8'h33, 8'h37, 8'h39, 8'h00, 8'h5F, 8'h4F, 8'h47,
				8'h43, 8'h41, 8'h61, 8'h71, 8'h79, 8'h7D, 8'h7F
			};
			debounce_lim = DEBOUNCE_LIMIT_RST;
			gap_lim = DECODE_GAP_LIMIT_RST;
			col_ticks = COLUMN_TICKS_RST;
			dash_lim = DASH_LIMIT_RST;
			key_mode = MODE_IDLE;
			line_mode = MODE_IDLE;
			release_cnt = '0;
			gap_cnt = '0;
			column_cnt = '0;
			mark_cols = '0;
			symbol = 8'd1;
			slot_pos = '0;
			errors = 0;
			chars_seen = 0;
			ticks_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [15:0] value);
			case (idx)
				CFG_DEBOUNCE_LIMIT: debounce_lim = value;
				CFG_DECODE_GAP_LIMIT: gap_lim = value;
				CFG_COLUMN_TICKS: col_ticks = value[7:0];
				CFG_DASH_LIMIT: dash_lim = value[7:0];
				default: ;
			endcase
		endfunction

		// The unused table entry is zero and can never equal a code with its low bit set.
		function logic [GLYPH_W-1:0] find_glyph(bit [7:0] sym);
			bit [7:0] code;
			code = {sym[6:0], 1'b1};
			for (int i = 0; i < GLYPH_COUNT; i++) begin
				if (glyph_codes[i] == code) return GLYPH_W'(i);
			end
			return UNKNOWN_GLYPH;
		endfunction

		function void note_tick(bit pressed);
			key_ev_t ev;
			line_res_t res;
			ev = EV_NONE;
			res = '0;
			case (key_mode)
				MODE_DOWN: begin
					if (pressed) begin
						release_cnt = '0;
					end else begin
						if (release_cnt != 16'hFFFF) release_cnt++;
						if (release_cnt > debounce_lim) begin
							ev = EV_UP;
							release_cnt = '0;
							key_mode = MODE_UP;
						end
					end
				end
				MODE_UP: begin
					if (pressed) begin
						gap_cnt = '0;
						ev = EV_DOWN;
						key_mode = MODE_DOWN;
					end else begin
						if (gap_cnt != 16'hFFFF) gap_cnt++;
						if (gap_cnt > gap_lim) begin
							ev = EV_GAP;
							gap_cnt = '0;
							key_mode = MODE_IDLE;
						end
					end
				end
				default: begin
					key_mode = pressed ? MODE_DOWN : MODE_IDLE;
					if (pressed) ev = EV_DOWN;
				end
			endcase
			if (ev != EV_NONE) begin
				line_mode = mode_t'(ev);
				column_cnt = '0;
			end
			case (line_mode)
				MODE_DOWN: begin
					if (column_cnt != 8'hFF) column_cnt++;
					if (column_cnt > col_ticks) begin
						res.line_action = ACT_MARK;
						if (mark_cols != 8'hFF) mark_cols++;
						column_cnt = '0;
					end
					res.tone_on = 1'b1;
				end
				MODE_UP: begin
					if (column_cnt != 8'hFF) column_cnt++;
					if (column_cnt > col_ticks) begin
						res.line_action = ACT_SPACE;
						if (mark_cols != 0) begin
							symbol = {symbol[6:0], mark_cols > dash_lim};
							mark_cols = '0;
						end
						column_cnt = '0;
					end
				end
				MODE_GAP: begin
					res.line_action = ACT_GAP;
					if (slot_pos >= SLOT_COUNT_DEF) begin
						slot_pos = '0;
						res.row_wrapped = 1'b1;
					end
					res.char_index = find_glyph(symbol);
					res.char_slot = slot_pos[SLOT_OUT_W-1:0];
					res.char_valid = 1'b1;
					slot_pos++;
					symbol = 8'd1;
					line_mode = MODE_IDLE;
					chars_seen++;
				end
				default: line_mode = MODE_IDLE;
			endcase
			pending_results.push_back(res);
			ticks_seen++;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT) $display("%0.1f ns: %s", $realtime, msg);
		endtask

		task check_result(line_res_t got);
			line_res_t want;
			if (pending_results.size() == 0) begin
				report("result arrived with no tick pending");
				return;
			end
			want = pending_results.pop_front();
			if (got.tone_on !== want.tone_on)
				report($sformatf("tone_on %0b, predicted %0b", got.tone_on, want.tone_on));
			if (got.line_action !== want.line_action)
				report($sformatf("line_action %0d, predicted %0d",
					got.line_action, want.line_action));
			if (got.char_valid !== want.char_valid)
				report($sformatf("char_valid %0b, predicted %0b",
					got.char_valid, want.char_valid));
			if (got.char_index !== want.char_index)
				report($sformatf("char_index %0d, predicted %0d",
					got.char_index, want.char_index));
			if (got.char_slot !== want.char_slot)
				report($sformatf("char_slot %0d, predicted %0d", got.char_slot, want.char_slot));
			if (got.row_wrapped !== want.row_wrapped)
				report($sformatf("row_wrapped %0b, predicted %0b",
					got.row_wrapped, want.row_wrapped));
		endtask

		task check_leftovers();
			if (pending_results.size() != 0)
				report($sformatf("%0d predicted results never arrived", pending_results.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;

	mkd_cfg_if cfg_ch();
	mkd_key_if key_ch();
	mkd_res_if res_ch();

	morse_key_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.key(key_ch),
		.result(res_ch)
	);

	decode_tracker tracker;
	bit send_idle;
	bit recv_idle;
	int recv_stall;
	int idle_cycles;
	int cfg_writes;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		res_ch.ready = 1'b0;
		recv_stall = 0;
		forever begin
			@(negedge clk);
			if (recv_stall > 0) begin
				recv_stall--;
				res_ch.ready <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 7) == 0) begin
				recv_stall = $urandom_range(0, 9);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		line_res_t seen;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen.tone_on = res_ch.tone_on;
			seen.line_action = line_act_t'(res_ch.line_action);
			seen.char_valid = res_ch.char_valid;
			seen.char_index = res_ch.char_index;
			seen.char_slot = res_ch.char_slot;
			seen.row_wrapped = res_ch.row_wrapped;
			tracker.check_result(seen);
		end
	end

	initial idle_cycles = 0;

	always @(posedge clk) begin
		if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_tick(bit pressed);
		if (send_idle && $urandom_range(0, 7) == 0) begin
			key_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		key_ch.valid <= 1'b1;
		key_ch.key_pressed <= pressed;
		do @(posedge clk); while (!key_ch.ready);
		tracker.note_tick(pressed);
		@(negedge clk);
	endtask

	task automatic send_run(bit pressed, int count);
		repeat (count) send_tick(pressed);
	endtask

	task automatic send_noise(int count);
		repeat (count) send_tick($urandom_range(0, 1));
	endtask

	// Stops sending and waits until every predicted result has been taken.
	task automatic drain();
		key_ch.valid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value[15:0];
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.write_reg(idx, value[15:0]);
		cfg_writes++;
		@(negedge clk);
	endtask

	task automatic set_timing(int unsigned db, int unsigned gap, int unsigned ct,
			int unsigned dash);
		drain();
		write_reg(CFG_DEBOUNCE_LIMIT, db);
		write_reg(CFG_DECODE_GAP_LIMIT, gap);
		write_reg(CFG_COLUMN_TICKS, ct);
		write_reg(CFG_DASH_LIMIT, dash);
		cfg_ch.valid <= 1'b0;
	endtask

	// The highest set bit of sym marks the length; each lower bit is one element, 1 a dash.
	task automatic send_symbol(bit [8:0] sym);
		int db;
		int gl;
		int ct;
		int dl;
		int n;
		int cols;
		int down;
		int space;
		db = tracker.debounce_lim;
		gl = tracker.gap_lim;
		ct = tracker.col_ticks;
		dl = tracker.dash_lim;
		n = 0;
		for (int i = 8; i > 0; i--) begin
			if (sym[i] && n == 0) n = i;
		end
		for (int i = n - 1; i >= 0; i--) begin
			if (sym[i])
				cols = dl + 1 + $urandom_range(0, 1);
			else
				cols = (dl == 0) ? 1 : $urandom_range(1, dl);
			down = cols * (ct + 1) + $urandom_range(0, ct);
			send_run(1'b1, (down > db) ? down - db : 1);
			if (i > 0)
				space = (ct <= gl) ? $urandom_range(db + ct + 1, db + gl + 1) : db + gl + 1;
			else
				space = db + gl + 2 + $urandom_range(0, 3);
			send_run(1'b0, space);
		end
	endtask

	task automatic random_symbol();
		int len;
		bit [8:0] sym;
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
		sym = (9'd1 << len) | (9'($urandom()) & ((9'd1 << len) - 9'd1));
		send_symbol(sym);
	endtask

	task automatic random_phase(int ticks_goal);
		int start;
		int pick;
		start = tracker.ticks_seen;
		while (tracker.ticks_seen - start < ticks_goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				random_symbol();
			end else if (pick < 9) begin
				send_noise($urandom_range(5, 40));
			end else begin
				drain();
				random_symbol();
			end
		end
	endtask

	initial begin
		int db;
		int ct;
		tracker = new();
		cfg_writes = 0;
		arst_n = 1'b0;
		key_ch.valid = 1'b0;
		key_ch.key_pressed = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_DEBOUNCE_LIMIT;
		cfg_ch.data = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_run(1'b1, 12);
		send_run(1'b0, 13);

		set_timing(0, 0, 0, 0);
		send_symbol(9'b0_0000_0101);
		send_noise(8);

		// Limits at their widest hold off the release, then a low limit lets it through.
		send_idle = 1'b0;
		recv_idle = 1'b0;
		set_timing(65535, 65535, 254, 254);
		send_run(1'b1, 3);
		send_run(1'b0, 20);
		set_timing(0, 0, 3, 1);
		send_run(1'b0, 3);

		send_idle = 1'b1;
		recv_idle = 1'b1;
		set_timing(0, 0, 0, 0);
		random_phase(40);
		set_timing(1, 3, 0, 1);
		random_phase(40);
		set_timing(2, 6, 1, 2);
		random_phase(40);
		set_timing(0, 2, 1, 0);
		random_phase(40);
		db = $urandom_range(0, 3);
		ct = $urandom_range(0, 2);
		set_timing(db, ct + $urandom_range(0, 8), ct, $urandom_range(0, 3));
		random_phase(40);

		send_idle = 1'b0;
		recv_idle = 1'b0;
		set_timing(0, 1, 0, 1);
		for (int g = 0; g < GLYPH_COUNT; g += 5) begin
			if (g != int'(UNKNOWN_GLYPH)) send_symbol({1'b0, tracker.glyph_codes[g]} >> 1);
		end
		random_phase(20);

		drain();
		repeat (8) @(posedge clk);
		tracker.check_leftovers();
		$display("Covered %0d key ticks over %0d register writes, %0d characters decoded.",
			tracker.ticks_seen, cfg_writes, tracker.chars_seen);
		$display("Included limits at both extremes, noise, a spread of glyphs and slot wrap.");
		if (tracker.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", tracker.errors);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
